### hdl/xsr_pkg.sv
// xsr_pkg: shared types and constants for the xorshift128+ generator with reseed.
// Used by xsr_core and xorshift128_plus_fill_rekey. No dependencies.
package xsr_pkg;

    localparam int WORD_W   = 64;
    localparam int THRESH_W = 40;
    localparam int CNT_W    = 41;
    localparam int BYTES_W  = 4;

    localparam logic [WORD_W-1:0]   GOLDEN_SEED     = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 40'd268435456;
    localparam logic [CNT_W-1:0]    COUNTER_MAX     = {CNT_W{1'b1}};
    localparam logic [BYTES_W-1:0]  MAX_WORD_BYTES  = 4'd8;

    localparam int SHIFT_A = 23;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 26;

    // command codes
    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_GEN  = 1'b1;

    typedef struct packed {
        logic                command;
        logic                first_of_fill;
        logic [BYTES_W-1:0]  byte_count;
        logic [WORD_W-1:0]   entropy_low;
        logic [WORD_W-1:0]   entropy_high;
    } xsr_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [CNT_W-1:0]  bytes_since_seed;
    } xsr_state_t;

    typedef struct packed {
        logic [WORD_W-1:0]  random_word;
        logic [BYTES_W-1:0] valid_bytes;
        logic               reseeded;
    } xsr_result_t;

endpackage

### hdl/xsr_core.sv
// xsr_core: one request's worth of work: a seed load, or an optional reseed, one xorshift128+
// step and a saturating byte counter. Pure combinational logic; depends on xsr_pkg.
module xsr_core
    import xsr_pkg::*;
(
    input  xsr_req_t              req,
    input  xsr_state_t            state,
    input  logic [THRESH_W-1:0]   rekey_threshold,
    output xsr_state_t            state_next,
    output xsr_result_t           result
);

    logic [WORD_W-1:0]  seed_lo;
    logic [WORD_W-1:0]  seed_hi;
    logic               do_reseed;
    logic [WORD_W-1:0]  x;
    logic [WORD_W-1:0]  y;
    logic [WORD_W-1:0]  x_mix;
    logic [WORD_W-1:0]  hi_new;
    logic [BYTES_W-1:0] count_sat;
    logic [CNT_W-1:0]   cnt_base;
    logic [CNT_W:0]     cnt_sum;

    always_comb
    begin
        seed_lo = req.entropy_low;
        // all-zero seed would lock the generator at zero
        if (req.entropy_low == '0 && req.entropy_high == '0)
        begin
            seed_hi = GOLDEN_SEED;
        end
        else
        begin
            seed_hi = req.entropy_high;
        end

        do_reseed = req.first_of_fill &&
                    (state.bytes_since_seed >= {1'b0, rekey_threshold});

        count_sat = (req.byte_count > MAX_WORD_BYTES) ? MAX_WORD_BYTES : req.byte_count;

        x        = do_reseed ? seed_lo : state.lo;
        y        = do_reseed ? seed_hi : state.hi;
        cnt_base = do_reseed ? '0 : state.bytes_since_seed;

        x_mix  = x ^ (x << SHIFT_A);
        hi_new = x_mix ^ y ^ (x_mix >> SHIFT_B) ^ (y >> SHIFT_C);

        cnt_sum = {1'b0, cnt_base} + {{(CNT_W+1-BYTES_W){1'b0}}, count_sat};

        case (req.command)
            CMD_SEED:
            begin
                state_next.lo               = seed_lo;
                state_next.hi               = seed_hi;
                state_next.bytes_since_seed = '0;
                result.random_word          = '0;
                result.valid_bytes          = '0;
                result.reseeded             = 1'b1;
            end
            CMD_GEN:
            begin
                state_next.lo               = y;
                state_next.hi               = hi_new;
                state_next.bytes_since_seed = cnt_sum[CNT_W] ? COUNTER_MAX
                                                             : cnt_sum[CNT_W-1:0];
                result.random_word          = hi_new + y;
                result.valid_bytes          = count_sat;
                result.reseeded             = do_reseed;
            end
            default:
            begin
                state_next = state;
                result     = '0;
            end
        endcase
    end

endmodule

### hdl/xorshift128_plus_fill_rekey.sv
// xorshift128_plus_fill_rekey: xorshift128+ word generator with threshold reseeding.
// Pipeline: 2 register stages (input reg, result reg); m_tvalid follows the result reg.
// Throughput: 1 request per cycle unless m_tready stalls; state_reg updates via xsr_core.
// Reset (rst_n, async, active low): state_lo = 0, state_hi = golden constant,
// byte counter = 0, rekey_threshold = 268435456, both pipeline stages empty.
module xorshift128_plus_fill_rekey
    import xsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [THRESH_W-1:0]  cfg_wdata,    // rekey_threshold

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [135:0]         s_tdata,      // byte_count[3:0], entropy_low[67:4],
                                               // entropy_high[131:68], zero pad
    input  logic [1:0]           s_tuser,      // command[0], first_of_fill[1]

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,      // random_word[63:0], valid_bytes[67:64],
                                               // zero pad
    output logic                 m_tuser       // reseeded
);

    logic [THRESH_W-1:0] thresh_reg;
    logic                in_valid_reg;
    xsr_req_t            in_req_reg;
    logic                out_valid_reg;
    xsr_result_t         out_res_reg;
    xsr_state_t          state_reg;
    xsr_state_t          state_next;
    xsr_result_t         res_next;
    logic                advance;
    logic                fire;
    xsr_req_t            s_req;

    assign s_req.command       = s_tuser[0];
    assign s_req.first_of_fill = s_tuser[1];
    assign s_req.byte_count    = s_tdata[3:0];
    assign s_req.entropy_low   = s_tdata[67:4];
    assign s_req.entropy_high  = s_tdata[131:68];

    // result register can take a new value
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    xsr_core u_core (
        .req             (in_req_reg),
        .state           (state_reg),
        .rekey_threshold (thresh_reg),
        .state_next      (state_next),
        .result          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg                 <= THRESHOLD_RESET;
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            state_reg.lo               <= '0;
            state_reg.hi               <= GOLDEN_SEED;
            state_reg.bytes_since_seed <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg <= s_req;
        end
        if (fire)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_res_reg.valid_bytes, out_res_reg.random_word};
    assign m_tuser  = out_res_reg.reseeded;

    // xorshift state is invertible, so a nonzero state never collapses to zero
    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.lo == '0 && state_reg.hi == '0))
        else $error("generator state reached all zero");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(state_reg))
        else $error("state changed without a request being processed");

    a_counter_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_since_seed < $past(state_reg.bytes_since_seed))
        |-> (state_reg.bytes_since_seed <= {{(CNT_W-BYTES_W){1'b0}}, MAX_WORD_BYTES}))
        else $error("byte counter fell without a reseed");

    a_valid_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.valid_bytes <= MAX_WORD_BYTES))
        else $error("valid_bytes above word size");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input stage dropped a request while stalled");

endmodule

### tb/sv/tb_xorshift128_plus_fill_rekey.sv
// tb_xorshift128_plus_fill_rekey: self-checking stream testbench for the xorshift128+
// generator with threshold reseeding. Directed table, then fill-shaped random traffic.
// Depends on xsr_pkg and xorshift128_plus_fill_rekey.
`timescale 1ns / 100ps

module tb_xorshift128_plus_fill_rekey;
    import xsr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 400;
    localparam int NUM_PHASES   = 5;
    localparam int STEADY_PHASE = 2;
    localparam int DIR_ROWS     = 18;
    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    typedef struct packed {
        logic               command;
        logic               first_of_fill;
        logic [BYTES_W-1:0] byte_count;
        logic [WORD_W-1:0]  entropy_low;
        logic [WORD_W-1:0]  entropy_high;
        logic               fixed;      // use want below instead of the predictor
        xsr_result_t        want;
    } dir_row_t;

    localparam xsr_result_t SEED_ACK = '{random_word: '0, valid_bytes: '0, reseeded: 1'b1};
    localparam xsr_result_t NO_WANT  = '0;

    // threshold stays at its reset value for the whole table
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{CMD_GEN,  1'b0, 4'd8,  64'h0, 64'h0, 1'b0, NO_WANT},     // straight out of reset
        '{CMD_GEN,  1'b1, 4'd8,  ONES,  ONES,  1'b0, NO_WANT},     // fill start, under threshold
        '{CMD_GEN,  1'b0, 4'd0,  64'h0, 64'h0, 1'b0, NO_WANT},     // zero bytes still advances
        '{CMD_GEN,  1'b0, 4'd15, 64'h0, 64'h0, 1'b0, NO_WANT},     // clamps to eight
        '{CMD_GEN,  1'b0, 4'd9,  64'h0, 64'h0, 1'b0, NO_WANT},
        '{CMD_SEED, 1'b0, 4'd8,  64'h0, 64'h0, 1'b1, SEED_ACK},    // all-zero seed -> golden
        '{CMD_GEN,  1'b0, 4'd8,  64'h0, 64'h0, 1'b0, NO_WANT},
        '{CMD_SEED, 1'b1, 4'd15, ONES,  ONES,  1'b1, SEED_ACK},    // extra fields ignored
        '{CMD_GEN,  1'b1, 4'd1,  64'h0, 64'h0, 1'b0, NO_WANT},
        '{CMD_GEN,  1'b0, 4'd8,  ONES,  64'h0, 1'b0, NO_WANT},
        '{CMD_SEED, 1'b0, 4'd0,  64'h1, 64'h0, 1'b1, SEED_ACK},
        '{CMD_GEN,  1'b0, 4'd5,  64'h0, 64'h0, 1'b0, NO_WANT},
        '{CMD_SEED, 1'b0, 4'd8,  64'h0, 64'h8000_0000_0000_0000, 1'b1, SEED_ACK},
        '{CMD_GEN,  1'b1, 4'd7,  64'h0, 64'h0, 1'b0, NO_WANT},
        '{CMD_GEN,  1'b0, 4'd2,  64'h0, 64'h0, 1'b0, NO_WANT},
        '{CMD_SEED, 1'b1, 4'd8,  64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
          1'b1, SEED_ACK},
        '{CMD_GEN,  1'b0, 4'd3,  64'h0, 64'h0, 1'b0, NO_WANT},
        '{CMD_GEN,  1'b0, 4'd8,  ONES,  ONES,  1'b0, NO_WANT}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [THRESH_W-1:0] cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [135:0]        s_tdata = '0;     // byte_count, entropy_low, entropy_high, pad
    logic [1:0]          s_tuser = '0;     // command, first_of_fill
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [71:0]         m_tdata;          // random_word, valid_bytes, pad
    logic                m_tuser;          // reseeded

    // generator mirror
    logic [WORD_W-1:0]   gen_lo;
    logic [WORD_W-1:0]   gen_hi;
    logic [CNT_W-1:0]    gen_bytes;
    logic [THRESH_W-1:0] gen_threshold;

    xsr_result_t         word_q[$];
    int                  mismatches = 0;
    int                  cycle_count = 0;
    int                  fill_left = 0;
    logic                steady = 1'b0;

    xorshift128_plus_fill_rekey u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void load_entropy(input logic [WORD_W-1:0] lo,
                                         input logic [WORD_W-1:0] hi);
        gen_lo    = lo;
        gen_hi    = (lo == '0 && hi == '0) ? GOLDEN_SEED : hi;
        gen_bytes = '0;
    endfunction

    function automatic xsr_result_t next_word(input xsr_req_t rq);
        xsr_result_t        res;
        logic [WORD_W-1:0]  x;
        logic [WORD_W-1:0]  y;
        logic [BYTES_W-1:0] used;
        res = '0;
        if (rq.command == CMD_SEED)
        begin
            load_entropy(rq.entropy_low, rq.entropy_high);
            res.reseeded = 1'b1;
            return res;
        end
        if (rq.first_of_fill && gen_bytes >= CNT_W'(gen_threshold))
        begin
            load_entropy(rq.entropy_low, rq.entropy_high);
            res.reseeded = 1'b1;
        end
        used   = (rq.byte_count > MAX_WORD_BYTES) ? MAX_WORD_BYTES : rq.byte_count;
        x      = gen_lo;
        y      = gen_hi;
        x      = x ^ (x << SHIFT_A);
        gen_lo = y;
        gen_hi = x ^ y ^ (x >> SHIFT_B) ^ (y >> SHIFT_C);
        res.random_word = gen_hi + y;
        res.valid_bytes = used;
        if (gen_bytes > COUNTER_MAX - CNT_W'(used))
            gen_bytes = COUNTER_MAX;
        else
            gen_bytes = gen_bytes + CNT_W'(used);
        return res;
    endfunction

    // drive one request, return the predicted word once it has been taken
    task automatic send_request(input xsr_req_t rq, output xsr_result_t pred);
        while (!steady && $urandom_range(99) < 35)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, rq.entropy_high, rq.entropy_low, rq.byte_count};
        s_tuser  <= {rq.first_of_fill, rq.command};
        do
            @(posedge clk);
        while (!s_tready);
        pred = next_word(rq);
    endtask

    // mostly well-formed fills: start word, full words, partial tail
    function automatic xsr_req_t stream_request();
        xsr_req_t rq;
        int       pick;
        rq.entropy_low  = {$urandom, $urandom};
        rq.entropy_high = {$urandom, $urandom};
        if ($urandom_range(15) == 0)
        begin
            rq.entropy_low  = '0;
            rq.entropy_high = '0;
        end
        rq.command       = CMD_GEN;
        rq.first_of_fill = 1'b0;
        rq.byte_count    = MAX_WORD_BYTES;
        if (fill_left == 0)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                rq.command       = CMD_SEED;
                rq.first_of_fill = 1'($urandom_range(1));
                rq.byte_count    = BYTES_W'($urandom_range(15));
                return rq;
            end
            if (pick < 18)
            begin
                rq.command       = 1'($urandom_range(1));
                rq.first_of_fill = 1'($urandom_range(1));
                rq.byte_count    = BYTES_W'($urandom_range(15));
                return rq;
            end
            fill_left        = $urandom_range(12, 1);
            rq.first_of_fill = 1'b1;
        end
        if (fill_left == 1)
            rq.byte_count = BYTES_W'($urandom_range(8, 1));
        fill_left = fill_left - 1;
        return rq;
    endfunction

    always @(posedge clk)
    begin : result_check
        xsr_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (word_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: word %h bytes %0d reseeded %b",
                             m_tdata[63:0], m_tdata[67:64], m_tuser);
            end
            else
            begin
                want = word_q.pop_front();
                if (m_tdata[63:0] !== want.random_word || m_tdata[67:64] !== want.valid_bytes
                    || m_tuser !== want.reseeded)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: word %h/%h bytes %0d/%0d reseeded %b/%b (exp/got)",
                                 want.random_word, m_tdata[63:0], want.valid_bytes,
                                 m_tdata[67:64], want.reseeded, m_tuser);
                end
            end
        end
        m_tready <= steady || ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        xsr_req_t            rq;
        xsr_result_t         pred;
        logic [THRESH_W-1:0] thresholds [NUM_PHASES];

        thresholds = '{40'd0, 40'd1, 40'hFF_FFFF_FFFF, 40'd24,
                       THRESH_W'($urandom_range(300, 2))};
        gen_lo        = '0;
        gen_hi        = GOLDEN_SEED;
        gen_bytes     = '0;
        gen_threshold = THRESHOLD_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            rq.command       = DIR_TABLE[i].command;
            rq.first_of_fill = DIR_TABLE[i].first_of_fill;
            rq.byte_count    = DIR_TABLE[i].byte_count;
            rq.entropy_low   = DIR_TABLE[i].entropy_low;
            rq.entropy_high  = DIR_TABLE[i].entropy_high;
            send_request(rq, pred);
            word_q.insert(word_q.size(), DIR_TABLE[i].fixed ? DIR_TABLE[i].want : pred);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            s_tvalid <= 1'b0;
            while (word_q.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= thresholds[p];
            @(posedge clk);
            gen_threshold = thresholds[p];
            cfg_we    <= 1'b0;
            steady    = (p == STEADY_PHASE);
            fill_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                rq = stream_request();
                send_request(rq, pred);
                word_q.insert(word_q.size(), pred);
            end
        end

        s_tvalid <= 1'b0;
        steady = 1'b0;
        while (word_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hdl/xsr_pkg.sv
hdl/xsr_core.sv
hdl/xorshift128_plus_fill_rekey.sv
tb/sv/tb_xorshift128_plus_fill_rekey.sv
